>>> hw/rtl/ciqr_pkg.sv
// ----------------------------------------------------------------------------
// ciqr_pkg
// Shared constants for the circular identifier queue: command and status
// codes, field widths and the default slot count.
// ----------------------------------------------------------------------------
package ciqr_pkg;

	// default number of slots
	localparam int DEPTH_DEF = 32;

	// field widths
	localparam int CMD_W    = 3;
	localparam int ID_W     = 16;
	localparam int STATUS_W = 2;
	localparam int FRONT_W  = 5;
	localparam int COUNT_W  = 6;

	typedef logic [CMD_W-1:0]    cmd_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [ID_W-1:0]     id_t;

	// command codes
	localparam cmd_t CMD_PUSH   = 3'd0;
	localparam cmd_t CMD_POP    = 3'd1;
	localparam cmd_t CMD_PEEK   = 3'd2;
	localparam cmd_t CMD_CLEAR  = 3'd3;
	localparam cmd_t CMD_ROTATE = 3'd4;

	// status codes
	localparam status_t STAT_OK    = 2'd0;
	localparam status_t STAT_FULL  = 2'd1;
	localparam status_t STAT_EMPTY = 2'd2;

endpackage

>>> hw/rtl/ciqr_ram.sv
// ----------------------------------------------------------------------------
// ciqr_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module ciqr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hw/rtl/circular_id_queue_with_rotate.sv
// ----------------------------------------------------------------------------
// circular_id_queue_with_rotate
// Circular queue of 16-bit identifiers with push, pop, peek, clear and
// rotate commands; identifiers live in a RAM, valid marks in flip-flops.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Push, pop, peek,
// clear and the unused codes keep busy high through the execute state, in
// which the registered read of the head slot from the RAM is used, and the
// result appears in the next cycle with done high for exactly one cycle.
// Rotate checks one valid mark per cycle, stepping from the slot after the
// head, and keeps busy high until the scan reaches a valid slot or has gone
// a full lap; rotate on an empty queue finishes from the execute state like
// the other commands. The receiver cannot stall: each result is shown once
// and must be taken in that cycle. A new command may be issued in the same
// cycle as the previous result.
// ----------------------------------------------------------------------------
module circular_id_queue_with_rotate
	import ciqr_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [CMD_W-1:0]    command,
	input  logic [ID_W-1:0]     id_in,
	output logic                done,
	output logic [STATUS_W-1:0] status,
	output logic [ID_W-1:0]     id_out,
	output logic [FRONT_W-1:0]  front_out,
	output logic [COUNT_W-1:0]  count_out
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [IW-1:0] IDX_LAST = IW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	// controller states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;

	function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] idx);
		wrap_inc = (idx == IDX_LAST) ? '0 : idx + 1'b1;
	endfunction

	logic [1:0]       state_q;
	logic [IW-1:0]    head_q;
	logic [IW-1:0]    tail_q;
	logic [CW-1:0]    count_q;
	logic [DEPTH-1:0] valid_q;
	cmd_t             cmd_q;
	id_t              id_q;
	logic [IW-1:0]    cand_head_q;
	logic [IW-1:0]    cand_tail_q;
	logic [CW-1:0]    step_q;
	logic             done_q;
	status_t          status_q;
	id_t              id_out_q;
	logic [FRONT_W-1:0] front_q;
	logic [COUNT_W-1:0] count_out_q;

	logic    accept;
	logic    ram_we;
	id_t     ram_rdata;
	logic    is_full;
	logic    is_empty;
	logic    head_valid;
	logic    cand_valid;
	logic    scan_last;

	assign accept     = start && (state_q == ST_IDLE);
	assign is_full    = (count_q == CNT_FULL);
	assign is_empty   = (count_q == '0);
	assign head_valid = valid_q[head_q];
	assign cand_valid = valid_q[cand_head_q];
	assign scan_last  = (step_q == CNT_FULL);
	assign ram_we     = (state_q == ST_EXEC) && (cmd_q == CMD_PUSH) && !is_full;

	// slot value storage, head read on every transaction
	ciqr_ram #(
		.WIDTH(ID_W),
		.DEPTH(DEPTH)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (tail_q),
		.wdata (id_q),
		.re    (accept),
		.raddr (head_q),
		.rdata (ram_rdata)
	);

	// command capture
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= command;
			id_q  <= id_in;
		end
	end

	// controller, pointers, count and valid marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			valid_q     <= '0;
			cand_head_q <= '0;
			cand_tail_q <= '0;
			step_q      <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
					case (cmd_q)
						CMD_PUSH: begin
							if (!is_full) begin
								valid_q[tail_q] <= 1'b1;
								tail_q          <= wrap_inc(tail_q);
								count_q         <= count_q + 1'b1;
							end
						end
						CMD_POP: begin
							if (!is_empty) begin
								valid_q[head_q] <= 1'b0;
								head_q          <= wrap_inc(head_q);
								count_q         <= count_q - 1'b1;
							end
						end
						CMD_CLEAR: begin
							valid_q <= '0;
							head_q  <= '0;
							tail_q  <= '0;
							count_q <= '0;
						end
						CMD_ROTATE: begin
							if (!is_empty) begin
								state_q     <= ST_SCAN;
								done_q      <= 1'b0;
								cand_head_q <= wrap_inc(head_q);
								cand_tail_q <= wrap_inc(tail_q);
								step_q      <= CW'(1);
							end
						end
						default: begin
						end
					endcase
				end
				ST_SCAN: begin
					// one valid mark per cycle until a valid slot or a full lap
					if (cand_valid) begin
						head_q  <= cand_head_q;
						tail_q  <= cand_tail_q;
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end else if (scan_last) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end else begin
						cand_head_q <= wrap_inc(cand_head_q);
						cand_tail_q <= wrap_inc(cand_tail_q);
						step_q      <= step_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (state_q == ST_EXEC) begin
			status_q    <= STAT_OK;
			id_out_q    <= '0;
			front_q     <= FRONT_W'(head_q);
			count_out_q <= COUNT_W'(count_q);
			case (cmd_q)
				CMD_PUSH: begin
					if (is_full) begin
						status_q <= STAT_FULL;
					end else begin
						count_out_q <= COUNT_W'(count_q + 1'b1);
					end
				end
				CMD_POP: begin
					if (is_empty) begin
						status_q <= STAT_EMPTY;
					end else begin
						id_out_q    <= head_valid ? ram_rdata : '0;
						front_q     <= FRONT_W'(wrap_inc(head_q));
						count_out_q <= COUNT_W'(count_q - 1'b1);
					end
				end
				CMD_PEEK: begin
					if (is_empty) begin
						status_q <= STAT_EMPTY;
					end else begin
						id_out_q <= head_valid ? ram_rdata : '0;
					end
				end
				CMD_CLEAR: begin
					front_q     <= '0;
					count_out_q <= '0;
				end
				CMD_ROTATE: begin
					if (is_empty) begin
						status_q <= STAT_EMPTY;
					end
				end
				default: begin
				end
			endcase
		end else if (state_q == ST_SCAN) begin
			status_q    <= cand_valid ? STAT_OK : STAT_EMPTY;
			id_out_q    <= '0;
			front_q     <= FRONT_W'(cand_valid ? cand_head_q : head_q);
			count_out_q <= COUNT_W'(count_q);
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign done      = done_q;
	assign status    = status_q;
	assign id_out    = id_out_q;
	assign front_out = front_q;
	assign count_out = count_out_q;

endmodule
